@@ rtl/iplpm_pkg.sv @@
// Shared types and constants for the IPv4 longest-prefix-match forwarder.
`default_nettype none
package iplpm_pkg;
  localparam int unsigned AddrW = 32;
  localparam int unsigned WordW = 16;
  localparam int unsigned LenW = 6;
  localparam int unsigned VerdW = 3;
  localparam int unsigned TtlW = 8;
  localparam int unsigned SumW = 21;
  localparam int unsigned CountW = 5;
  localparam logic [CountW-1:0] WordIhl = 5'd0;
  localparam logic [CountW-1:0] WordTtl = 5'd4;
  localparam logic [CountW-1:0] WordCsum = 5'd5;
  localparam logic [CountW-1:0] WordDstHi = 5'd8;
  localparam logic [CountW-1:0] WordDstLo = 5'd9;
  localparam logic [3:0] MinIhl = 4'd5;
  localparam logic [LenW-1:0] MaxLen = 6'd32;

  typedef enum logic [VerdW-1:0] {
    V_ADDED   = 3'd0,
    V_FULL    = 3'd1,
    V_LOCAL   = 3'd2,
    V_TTL     = 3'd3,
    V_NOROUTE = 3'd4,
    V_FORWARD = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_ADD_RD, S_ADD_WAIT, S_ADD_STEP, S_LK_RD, S_LK_WAIT, S_LK_STEP
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_step;   // write zero to node at clear index
    logic start_add;    // latch route and reset walk
    logic start_lookup; // reset walk for lookup
    logic read_node;    // issue read of current node
    logic add_step;     // act on the read node for an add
    logic lk_step;      // act on the read node for a lookup
    logic word_in;      // take a header word
    logic finish;       // latch the result word
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic add_done;
    logic lk_done;
    logic packet_end;   // the word being taken is the last of the header
    logic pre_decided;  // local or ttl verdict, no lookup needed
  } status_t;
endpackage
`default_nettype wire

@@ rtl/iplpm_if.sv @@
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface iplpm_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/iplpm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module iplpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/iplpm_datapath.sv @@
// Trie node memories, header parsing and result datapath.
`default_nettype none
module iplpm_datapath #(
  parameter int unsigned NodeCount = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire iplpm_pkg::cmd_t                  cmd,
  output      iplpm_pkg::status_t               status,
  input  wire logic [iplpm_pkg::WordW-1:0]      word,
  input  wire logic [iplpm_pkg::AddrW-1:0]      in_prefix,
  input  wire logic [iplpm_pkg::LenW-1:0]       in_length,
  input  wire logic [iplpm_pkg::AddrW-1:0]      in_hop,
  input  wire logic [iplpm_pkg::AddrW-1:0]      local_address,
  output      logic [iplpm_pkg::VerdW-1:0]      res_verdict,
  output      logic [iplpm_pkg::AddrW-1:0]      res_hop,
  output      logic [iplpm_pkg::TtlW-1:0]       res_ttl,
  output      logic [iplpm_pkg::WordW-1:0]      res_csum
);
  localparam int unsigned IdxW = $clog2(NodeCount);
  localparam int unsigned UsedW = $clog2(NodeCount + 1);
  localparam int unsigned NodeW = 2 * IdxW + 1;
  localparam int unsigned CountW_l = iplpm_pkg::CountW;

  // Node word: {valid, left, right}; hop value kept in its own RAM.
  logic [IdxW-1:0]  node;
  logic [IdxW-1:0]  clear_idx;
  logic [UsedW-1:0] nodes_used;
  logic [iplpm_pkg::AddrW-1:0] prefix, hop_in, best_hop, dst;
  logic [iplpm_pkg::LenW-1:0]  len, depth;
  logic found;
  logic [NodeW-1:0] node_rd, node_wd;
  logic [iplpm_pkg::AddrW-1:0] hop_rd;
  logic node_we, hop_we;
  logic [IdxW-1:0] node_wa;
  logic [CountW_l-1:0] word_count;
  logic [3:0] header_length;
  logic [iplpm_pkg::SumW-1:0] running_sum;
  logic [iplpm_pkg::TtlW-1:0] ttl;

  iplpm_ram #(.Width(NodeW), .Depth(NodeCount)) u_node (
    .clk, .we(node_we), .waddr(node_wa), .wdata(node_wd), .raddr(node), .rdata(node_rd)
  );
  iplpm_ram #(.Width(iplpm_pkg::AddrW), .Depth(NodeCount)) u_hop (
    .clk, .we(hop_we), .waddr(node), .wdata(hop_in), .raddr(node), .rdata(hop_rd)
  );

  logic rd_valid;
  logic [IdxW-1:0] rd_left, rd_right, child;
  logic bit_sel, add_end, pool_full, lk_bit;
  logic [5:0] bit_pos;
  assign rd_valid = node_rd[NodeW-1];
  assign rd_left = node_rd[2*IdxW-1:IdxW];
  assign rd_right = node_rd[IdxW-1:0];
  assign bit_pos = 6'd31 - depth;
  assign bit_sel = prefix[bit_pos[4:0]];
  assign lk_bit = dst[bit_pos[4:0]];
  assign add_end = (depth == len);
  assign pool_full = (nodes_used == UsedW'(NodeCount));

  always_comb begin
    node_we = 1'b0;
    node_wa = node;
    node_wd = node_rd;
    hop_we = 1'b0;
    child = (bit_sel) ? rd_right : rd_left;
    if (cmd.clear_step) begin
      node_we = 1'b1;
      node_wa = clear_idx;
      node_wd = '0;
    end else if (cmd.add_step) begin
      if (add_end) begin
        node_we = 1'b1;
        node_wd = {1'b1, rd_left, rd_right};
        hop_we = 1'b1;
      end else if (child == '0 && !pool_full) begin
        node_we = 1'b1;
        if (bit_sel) node_wd = {rd_valid, rd_left, nodes_used[IdxW-1:0]};
        else node_wd = {rd_valid, nodes_used[IdxW-1:0], rd_right};
      end
    end
  end

  logic [IdxW-1:0] lk_child;
  assign lk_child = lk_bit ? rd_right : rd_left;
  assign status.clear_done = (clear_idx == IdxW'(NodeCount - 1));
  assign status.add_done = cmd.add_step && (add_end || (child == '0 && pool_full));
  assign status.lk_done = cmd.lk_step && (depth == iplpm_pkg::MaxLen || lk_child == '0);
  assign status.packet_end =
      ({1'b0, word_count} + 6'd1) >= {1'b0, header_length, 1'b0};
  assign status.pre_decided = (dst == local_address) || (ttl == '0);

  logic [3:0] ihl;
  assign ihl = word[11:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_idx <= '0;
      nodes_used <= UsedW'(1);
      word_count <= '0;
      header_length <= iplpm_pkg::MinIhl;
      running_sum <= '0;
      dst <= '0;
      ttl <= '0;
      node <= '0;
    end else begin
      if (cmd.clear_step) clear_idx <= clear_idx + IdxW'(1);
      if (cmd.start_add) begin
        prefix <= in_prefix;
        len <= (in_length > iplpm_pkg::MaxLen) ? iplpm_pkg::MaxLen : in_length;
        hop_in <= in_hop;
        depth <= '0;
        node <= '0;
      end
      if (cmd.start_lookup) begin
        depth <= '0;
        node <= '0;
        found <= 1'b0;
      end
      if (cmd.add_step && !add_end) begin
        depth <= depth + 6'd1;
        if (child == '0) begin
          if (!pool_full) begin
            node <= nodes_used[IdxW-1:0];
            nodes_used <= nodes_used + UsedW'(1);
          end
        end else node <= child;
      end
      if (cmd.lk_step) begin
        if (rd_valid) begin
          found <= 1'b1;
          best_hop <= hop_rd;
        end
        depth <= depth + 6'd1;
        node <= lk_child;
      end
      if (cmd.word_in) begin
        if (word_count == iplpm_pkg::WordIhl)
          header_length <= (ihl < iplpm_pkg::MinIhl) ? iplpm_pkg::MinIhl : ihl;
        if (word_count == iplpm_pkg::WordTtl) ttl <= word[15:8];
        if (word_count == iplpm_pkg::WordDstHi) dst[31:16] <= word;
        if (word_count == iplpm_pkg::WordDstLo) dst[15:0] <= word;
        if (word_count != iplpm_pkg::WordCsum)
          running_sum <= running_sum + iplpm_pkg::SumW'(word);
        word_count <= word_count + CountW_l'(1);
      end
      if (cmd.finish) begin
        word_count <= '0;
        header_length <= iplpm_pkg::MinIhl;
        running_sum <= '0;
        dst <= '0;
        ttl <= '0;
      end
    end
  end

  // Result: the lookup's last node is folded into found and best_hop in lk_step, before finish reads them.
  logic [iplpm_pkg::SumW-1:0] s0;
  logic [16:0] s1;
  logic [16:0] s2;
  logic fin_found;
  logic [iplpm_pkg::AddrW-1:0] fin_hop;
  assign s0 = running_sum - iplpm_pkg::SumW'(256);
  assign s1 = {1'b0, s0[15:0]} + 17'(s0[20:16]);
  assign s2 = {1'b0, s1[15:0]} + 17'(s1[16]);
  assign fin_found = found;
  assign fin_hop = best_hop;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_hop <= '0;
      res_ttl <= '0;
      res_csum <= '0;
      if (dst == local_address) res_verdict <= iplpm_pkg::V_LOCAL;
      else if (ttl == '0) res_verdict <= iplpm_pkg::V_TTL;
      else if (!fin_found) res_verdict <= iplpm_pkg::V_NOROUTE;
      else begin
        res_verdict <= iplpm_pkg::V_FORWARD;
        res_hop <= fin_hop;
        res_ttl <= ttl - 8'd1;
        res_csum <= ~s2[15:0];
      end
    end else if (status.add_done) begin
      res_hop <= '0;
      res_ttl <= '0;
      res_csum <= '0;
      res_verdict <= add_end ? iplpm_pkg::V_ADDED : iplpm_pkg::V_FULL;
    end
  end
endmodule
`default_nettype wire

@@ rtl/iplpm_ctrl.sv @@
// Controller state machine sequencing clear, route add and lookup.
`default_nettype none
module iplpm_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_mode,
  output      logic                in_ready,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      iplpm_pkg::cmd_t     cmd,
  input  wire iplpm_pkg::status_t  status
);
  iplpm_pkg::state_t state, state_next;
  logic out_valid_next;
  logic pending, pending_next; // a finished header waits for its verdict slot

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iplpm_pkg::S_CLEAR;
      out_valid <= 1'b0;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
      pending <= pending_next;
    end
  end

  logic take, slot_free;
  assign slot_free = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    pending_next = pending;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      iplpm_pkg::S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_done) state_next = iplpm_pkg::S_IDLE;
      end
      iplpm_pkg::S_IDLE: begin
        in_ready = slot_free;
        if (take) begin
          if (!in_mode) begin
            cmd.start_add = 1'b1;
            state_next = iplpm_pkg::S_ADD_RD;
          end else begin
            cmd.word_in = 1'b1;
            if (status.packet_end) state_next = iplpm_pkg::S_LK_RD;
          end
        end
      end
      iplpm_pkg::S_ADD_RD: state_next = iplpm_pkg::S_ADD_WAIT;
      iplpm_pkg::S_ADD_WAIT: state_next = iplpm_pkg::S_ADD_STEP;
      iplpm_pkg::S_ADD_STEP: begin
        cmd.add_step = 1'b1;
        if (status.add_done) begin
          out_valid_next = 1'b1;
          state_next = iplpm_pkg::S_IDLE;
        end else state_next = iplpm_pkg::S_ADD_WAIT;
      end
      iplpm_pkg::S_LK_RD: begin
        cmd.start_lookup = 1'b1;
        state_next = iplpm_pkg::S_LK_WAIT;
      end
      iplpm_pkg::S_LK_WAIT: state_next = iplpm_pkg::S_LK_STEP;
      iplpm_pkg::S_LK_STEP: begin
        cmd.lk_step = !pending;
        if (pending || status.lk_done || status.pre_decided) begin
          pending_next = 1'b1;
          if (slot_free && (pending || status.pre_decided)) begin
            cmd.lk_step = 1'b0;
            cmd.finish = 1'b1;
            out_valid_next = 1'b1;
            pending_next = 1'b0;
            state_next = iplpm_pkg::S_IDLE;
          end
        end else state_next = iplpm_pkg::S_LK_WAIT;
      end
      default: state_next = iplpm_pkg::S_IDLE;
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.add_step && cmd.lk_step)) else $error("add and lookup step together");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == iplpm_pkg::S_IDLE) else $error("ready outside idle");
  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> slot_free) else $error("result overwrites waiting word");
endmodule
`default_nettype wire

@@ rtl/ipv4_forward_lpm_trie.sv @@
// Top level of the IPv4 forwarder with binary-trie longest-prefix match.
// After reset a clearing pass zeroes the node memory; no item is taken meanwhile.
// The last header word starts a trie walk of up to 33 node reads through the single
// node-RAM port, and then the verdict is issued. A route add reads at most one node
// for each bit of its route_length (capped at 32) plus one. Results wait in an output
// register, which holds off the next item while it is full; one item is in work
// at a time.
`default_nettype none
module ipv4_forward_lpm_trie #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input wire logic clk,
  input wire logic rst,
  iplpm_if.sink    cfg,
  iplpm_if.sink    in_ch,
  iplpm_if.source  out_ch
);
  logic [iplpm_pkg::AddrW-1:0] local_address;
  iplpm_pkg::cmd_t cmd;
  iplpm_pkg::status_t status;
  logic out_valid;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) local_address <= '0;
    else if (cfg.valid) local_address <= cfg.payload;
  end

  iplpm_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_mode(in_ch.payload.mode), .in_ready(in_ch.ready),
    .out_valid, .out_ready(out_ch.ready), .cmd, .status
  );

  iplpm_datapath #(.NodeCount(NODE_COUNT)) u_dp (
    .clk, .rst, .cmd, .status,
    .word(in_ch.payload.header_word), .in_prefix(in_ch.payload.route_prefix),
    .in_length(in_ch.payload.route_length), .in_hop(in_ch.payload.route_hop),
    .local_address,
    .res_verdict(out_ch.payload.verdict), .res_hop(out_ch.payload.next_hop),
    .res_ttl(out_ch.payload.new_ttl), .res_csum(out_ch.payload.new_checksum)
  );
  assign out_ch.valid = out_valid;
endmodule
`default_nettype wire

@@ dv/tb_iplpm_types_pkg.sv @@
// Word layouts of the forwarder's input and result channels, shared by the testbench files.
package tb_iplpm_types_pkg;
  import iplpm_pkg::*;

  typedef struct packed {
    logic              mode;
    logic [WordW-1:0]  header_word;
    logic [AddrW-1:0]  route_prefix;
    logic [LenW-1:0]   route_length;
    logic [AddrW-1:0]  route_hop;
  } fwd_in_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [AddrW-1:0]  next_hop;
    logic [TtlW-1:0]   new_ttl;
    logic [WordW-1:0]  new_checksum;
  } fwd_out_t;

  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_HDR = 1'b1;
endpackage

@@ dv/iplpm_checker.sv @@
// Route-table and header predictor that checks every result word of the forwarder.
module iplpm_checker #(
  parameter int unsigned NODE_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [31:0]            cfg_data,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  tb_iplpm_types_pkg::fwd_in_t  in_word,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  tb_iplpm_types_pkg::fwd_out_t out_word,
  output int                     pending,
  output int                     errors
);
  import iplpm_pkg::*;
  import tb_iplpm_types_pkg::*;

  int unsigned left_node [NODE_COUNT];
  int unsigned right_node [NODE_COUNT];
  bit          has_hop [NODE_COUNT];
  logic [31:0] hop_of [NODE_COUNT];
  int unsigned pool_used;
  logic [31:0] router_addr;
  int unsigned words_seen;
  int unsigned hdr_len;
  logic [31:0] hdr_sum;
  logic [31:0] hdr_dst;
  logic [7:0]  hdr_ttl;
  fwd_out_t    expected_results[$];

  function automatic verdict_t insert_route(logic [31:0] prefix, int unsigned len,
                                            logic [31:0] hop);
    int unsigned node;
    int unsigned nxt;
    node = 0;
    if (len > 32) len = 32;
    for (int i = 0; i < len; i++) begin
      nxt = prefix[31-i] ? right_node[node] : left_node[node];
      if (nxt == 0) begin
        if (pool_used >= NODE_COUNT) return V_FULL;
        nxt = pool_used;
        pool_used++;
        if (prefix[31-i]) right_node[node] = nxt;
        else left_node[node] = nxt;
      end
      node = nxt;
    end
    has_hop[node] = 1'b1;
    hop_of[node] = hop;
    return V_ADDED;
  endfunction

  function automatic bit longest_match(logic [31:0] addr, output logic [31:0] hop);
    int unsigned node;
    int unsigned nxt;
    bit found;
    node = 0;
    found = 0;
    hop = '0;
    for (int i = 0; i <= 32; i++) begin
      if (has_hop[node]) begin
        found = 1;
        hop = hop_of[node];
      end
      if (i == 32) break;
      nxt = addr[31-i] ? right_node[node] : left_node[node];
      if (nxt == 0) break;
      node = nxt;
    end
    return found;
  endfunction

  function automatic void take_word(fwd_in_t w);
    fwd_out_t r;
    logic [31:0] hop;
    logic [31:0] s;
    r = '0;
    if (w.mode == MODE_ADD) begin
      r.verdict = insert_route(w.route_prefix, w.route_length, w.route_hop);
      expected_results.push_back(r);
      return;
    end
    if (words_seen == WordIhl) hdr_len = (w.header_word[11:8] < MinIhl) ? MinIhl
                                                                          : w.header_word[11:8];
    if (words_seen == WordTtl) hdr_ttl = w.header_word[15:8];
    if (words_seen == WordDstHi) hdr_dst[31:16] = w.header_word;
    if (words_seen == WordDstLo) hdr_dst[15:0] = w.header_word;
    if (words_seen != WordCsum) hdr_sum = (hdr_sum + w.header_word) & 32'h1f_ffff;
    words_seen = (words_seen + 1) & 5'h1f;
    if (words_seen < 2 * hdr_len) return;
    if (hdr_dst == router_addr) r.verdict = V_LOCAL;
    else if (hdr_ttl == 0) r.verdict = V_TTL;
    else if (!longest_match(hdr_dst, hop)) r.verdict = V_NOROUTE;
    else begin
      r.verdict = V_FORWARD;
      r.next_hop = hop;
      r.new_ttl = hdr_ttl - 8'd1;
      s = hdr_sum - 32'h100;
      s = (s & 32'hffff) + (s >> 16);
      s = (s & 32'hffff) + (s >> 16);
      r.new_checksum = ~s[15:0];
    end
    expected_results.push_back(r);
    words_seen = 0;
    hdr_len = MinIhl;
    hdr_sum = 0;
    hdr_dst = 0;
    hdr_ttl = 0;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    fwd_out_t want;
    if (rst) begin
      for (int i = 0; i < NODE_COUNT; i++) begin
        left_node[i] = 0;
        right_node[i] = 0;
        has_hop[i] = 0;
        hop_of[i] = '0;
      end
      pool_used = 1;
      router_addr = '0;
      words_seen = 0;
      hdr_len = MinIhl;
      hdr_sum = 0;
      hdr_dst = 0;
      hdr_ttl = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) router_addr = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_word);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (out_word.verdict !== want.verdict || out_word.next_hop !== want.next_hop ||
              out_word.new_ttl !== want.new_ttl ||
              out_word.new_checksum !== want.new_checksum) begin
            $display("%0t: mismatch expected %s hop %h ttl %h csum %h, got %s hop %h ttl %h csum %h",
                     $time, want.verdict.name(), want.next_hop, want.new_ttl,
                     want.new_checksum, out_word.verdict.name(), out_word.next_hop,
                     out_word.new_ttl, out_word.new_checksum);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) take_word(in_word);
    end
    pending = expected_results.size();
  end
endmodule

@@ dv/tb_top.sv @@
// Stimulus, clocking and final verdict for the IPv4 longest-prefix-match forwarder.
module tb_top;
  import iplpm_pkg::*;
  import tb_iplpm_types_pkg::*;

  localparam int unsigned NODES = 1024;
  localparam int unsigned SETTLE = 100;

  logic clk;
  logic rst;
  int   sent_words;
  int   got_results;
  int   pending;
  int   errors;
  bit   calm;
  logic [31:0] known_routes[$];

  iplpm_if #(.payload_t(logic [31:0])) cfg_if ();
  iplpm_if #(.payload_t(fwd_in_t))     in_if ();
  iplpm_if #(.payload_t(fwd_out_t))    out_if ();

  ipv4_forward_lpm_trie #(.NODE_COUNT(NODES)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  iplpm_checker #(.NODE_COUNT(NODES)) u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_data  (cfg_if.payload),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_word   (in_if.payload),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_word  (out_if.payload),
    .pending   (pending),
    .errors    (errors)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Send one word; valid stays high into the next word when no gap is drawn.
  task automatic send_word(fwd_in_t w);
    int gap;
    bit took;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= w;
    do begin
      @(negedge clk);
      took = in_if.valid && in_if.ready;
      @(posedge clk);
    end while (!took);
    sent_words++;
  endtask

  task automatic add_route(logic [31:0] prefix, logic [5:0] len, logic [31:0] hop);
    fwd_in_t w;
    w = {$urandom, $urandom, $urandom};
    w.mode = MODE_ADD;
    w.route_prefix = prefix;
    w.route_length = len;
    w.route_hop = hop;
    send_word(w);
    known_routes.push_back(prefix);
  endtask

  task automatic send_packet(logic [3:0] ihl, logic [7:0] ttl, logic [31:0] dst,
                             bit mix_adds);
    fwd_in_t w;
    int unsigned count;
    count = 2 * ((ihl < MinIhl) ? MinIhl : ihl);
    for (int i = 0; i < count; i++) begin
      w = {$urandom, $urandom, $urandom};
      w.mode = MODE_HDR;
      w.header_word = $urandom;
      if (i == WordIhl) w.header_word[11:8] = ihl;
      if (i == WordTtl) w.header_word[15:8] = ttl;
      if (i == WordDstHi) w.header_word = dst[31:16];
      if (i == WordDstLo) w.header_word = dst[15:0];
      send_word(w);
      if (mix_adds && $urandom_range(0, 19) == 0)
        add_route($urandom, $urandom_range(0, 32), $urandom);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_local(logic [31:0] addr);
    bit took;
    wait_idle();
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= addr;
    do begin
      @(negedge clk);
      took = cfg_if.ready;
      @(posedge clk);
    end while (!took);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_dest(logic [31:0] local_addr);
    int unsigned r;
    logic [31:0] d;
    r = $urandom_range(0, 99);
    d = $urandom;
    if (r < 10) return local_addr;
    if (r < 70 && known_routes.size() > 0) begin
      d = known_routes[$urandom_range(0, known_routes.size() - 1)];
      if ($urandom_range(0, 1)) d[$urandom_range(0, 31)] ^= 1'b1;
      if ($urandom_range(0, 2) == 0) d[7:0] = $urandom;
    end
    return d;
  endfunction

  function automatic logic [7:0] pick_ttl();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return 8'd0;
    if (r == 2) return 8'd1;
    if (r == 3) return 8'hff;
    return $urandom_range(1, 255);
  endfunction

  function automatic logic [3:0] pick_ihl();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 2) return $urandom_range(0, 4);
    if (r < 4) return $urandom_range(6, 15);
    return 4'd5;
  endfunction

  task automatic random_phase(logic [31:0] local_addr, int words_to, int adds,
                              bit fill_pool);
    int unsigned len;
    for (int i = 0; i < adds; i++) begin
      len = fill_pool ? 32 : $urandom_range(0, 9) == 0 ? $urandom_range(33, 63)
                                                        : $urandom_range(0, 32);
      add_route($urandom, len, $urandom);
    end
    while (sent_words < words_to) begin
      if ($urandom_range(0, 9) == 0) add_route($urandom, $urandom_range(4, 32), $urandom);
      else send_packet(pick_ihl(), pick_ttl(), pick_dest(local_addr), 1'b1);
      if ($urandom_range(0, 99) == 0) calm = !calm;
    end
  endtask

  // Result side: random stalls, one long hold-off so the block backs up.
  initial begin
    int gap;
    bit took;
    out_if.ready = 1'b0;
    got_results = 0;
    @(negedge rst);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 3);
      if (got_results == 40) gap = 400;
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_if.valid && out_if.ready;
        @(posedge clk);
      end while (!took);
      got_results++;
    end
  end

  initial begin
    logic [31:0] addr;
    rst = 1'b1;
    calm = 0;
    sent_words = 0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: no route with an empty table, local, ttl zero, short IHL, /32 and /0.
    addr = 32'hc0a8_0001;
    write_local(addr);
    send_packet(4'd5, 8'd64, 32'h0a00_0001, 1'b0);
    add_route(32'h0a00_0001, 6'd32, 32'hffff_ffff);
    add_route(32'h0a00_0001, 6'd40, 32'h1111_2222);
    add_route(32'h0000_0000, 6'd0, 32'h0000_0000);
    add_route(32'h8000_0000, 6'd1, 32'h8080_8080);
    send_packet(4'd5, 8'd64, addr, 1'b0);
    send_packet(4'd5, 8'd0, 32'h0a00_0001, 1'b0);
    send_packet(4'd3, 8'd1, 32'h0a00_0001, 1'b0);
    send_packet(4'd15, 8'hff, 32'hffff_ffff, 1'b0);
    send_packet(4'd0, 8'h80, 32'h0a00_0002, 1'b0);

    // Hold the sender until every result is in.
    wait_idle();
    random_phase(addr, 430, 20, 1'b0);
    addr = 32'hffff_ffff;
    write_local(addr);
    random_phase(addr, 860, 10, 1'b0);
    addr = 32'h0;
    write_local(addr);
    random_phase(addr, 1400, 45, 1'b1);
    addr = $urandom;
    write_local(addr);
    random_phase(addr, 1450, 5, 1'b0);

    wait_idle();
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
